// ===== rtl/core/crsp_pkg.sv =====
// shared types and constants for the call record stream parser
`timescale 1ns / 1ps

package crsp_pkg;

  localparam int BYTE_W      = 8;
  localparam int NUM_W       = 64;
  localparam int DUR_W       = 24;
  localparam int DATE_BYTES  = 6;
  localparam int DUR_BYTES   = 3;
  localparam int SKIP_BYTES  = 2;
  localparam int FC_W        = 5;
  localparam int RBL_W       = 8;
  localparam int DIG_W       = 5;
  localparam int OUT_DATA_W  = 208;

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'd132;
  localparam logic [BYTE_W-1:0] TAG_DATE    = 8'd100;
  localparam logic [BYTE_W-1:0] TAG_BNUM    = 8'd101;
  localparam logic [BYTE_W-1:0] TAG_END     = 8'd168;
  localparam logic [BYTE_W-1:0] LEN_LIMIT   = 8'd32;
  localparam logic [BYTE_W-1:0] LEN_MASK    = 8'd15;
  localparam int                ANSWER_BIT  = 2;

  typedef enum logic [15:0] {
    PH_SEEK   = 16'h0001,
    PH_LEN    = 16'h0002,
    PH_SKIP_A = 16'h0004,
    PH_ANSWER = 16'h0008,
    PH_SKIP_B = 16'h0010,
    PH_ALEN   = 16'h0020,
    PH_ADIG   = 16'h0040,
    PH_TAG100 = 16'h0080,
    PH_DATE   = 16'h0100,
    PH_DSKIP  = 16'h0200,
    PH_DUR    = 16'h0400,
    PH_TAG101 = 16'h0800,
    PH_BLEN   = 16'h1000,
    PH_BDIG   = 16'h2000,
    PH_TAG168 = 16'h4000,
    PH_TAIL   = 16'h8000
  } phase_t;

  // last member sits in the low bits, so answered lands at bit 0
  typedef struct packed {
    logic                  tag168_seen;
    logic [DUR_W-1:0]      duration;
    logic [BYTE_W-1:0]     second_value;
    logic [BYTE_W-1:0]     minute_value;
    logic [BYTE_W-1:0]     hour_value;
    logic [BYTE_W-1:0]     day_value;
    logic [BYTE_W-1:0]     month_value;
    logic [BYTE_W-1:0]     year_value;
    logic [NUM_W-1:0]      callee_number;
    logic [NUM_W-1:0]      caller_number;
    logic                  answered;
  } record_t;

  localparam int RECORD_W = $bits(record_t);

  typedef struct packed {
    logic              take;
    logic [BYTE_W-1:0] data;
  } byte_xfer_t;

endpackage

// ===== rtl/core/crsp_in_reg.sv =====
// input byte register with stall control
`timescale 1ns / 1ps

module crsp_in_reg
  import crsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              advance,
  output byte_xfer_t        xfer
);

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              accept;

  assign in_tready = !vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (accept) begin
      vld_nxt  = 1'b1;
      data_nxt = in_tdata;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    data_r <= data_nxt;
  end

  assign xfer.take = vld_r && advance;
  assign xfer.data = data_r;

endmodule

// ===== rtl/core/crsp_parser.sv =====
// record parsing state machine, field capture and number accumulation
`timescale 1ns / 1ps

module crsp_parser
  import crsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  byte_xfer_t xfer,
  output logic       res_valid,
  output record_t    res
);

  phase_t             phase_r, phase_nxt;
  logic [RBL_W-1:0]   rbl_r, rbl_nxt;
  logic [FC_W-1:0]    fc_r, fc_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic               odd_r, odd_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic [NUM_W-1:0]   caller_r, caller_nxt;
  logic [NUM_W-1:0]   callee_r, callee_nxt;
  logic [BYTE_W-1:0]  date_r [DATE_BYTES];
  logic [BYTE_W-1:0]  date_nxt [DATE_BYTES];
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic               ans_r, ans_nxt;

  logic [BYTE_W-1:0]  b;
  logic [RBL_W-1:0]   rbl_dec;
  logic [FC_W-1:0]    fc_inc;
  logic [5:0]         len6;
  logic [6:0]         len_sum;
  logic [DIG_W-1:0]   dig_start;
  logic [DIG_W-1:0]   dig_dec;
  logic [3:0]         hi, lo;
  logic [BYTE_W-1:0]  hi_x10;
  logic [NUM_W-1:0]   acc_x10, acc_x100, acc_step;
  logic               do_finish;
  logic               end_tag;

  assign b       = xfer.data;
  assign rbl_dec = (rbl_r != '0) ? rbl_r - RBL_W'(1) : '0;
  assign fc_inc  = fc_r + FC_W'(1);
  assign end_tag = (b == TAG_END);

  // number length: values above the limit keep only the low nibble
  assign len6      = (b > LEN_LIMIT) ? 6'(b & LEN_MASK) : b[5:0];
  assign len_sum   = {1'b0, len6} + 7'd1;
  assign dig_start = len_sum[DIG_W:1];
  assign dig_dec   = (dig_r != '0) ? dig_r - DIG_W'(1) : '0;

  // one packed bcd byte: times 10 or 100 by shift and add
  assign hi       = b[7:4];
  assign lo       = b[3:0];
  assign hi_x10   = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0};
  assign acc_x10  = {acc_r[NUM_W-4:0], 3'b000} + {acc_r[NUM_W-2:0], 1'b0};
  assign acc_x100 = {acc_r[NUM_W-7:0], 6'b0} + {acc_r[NUM_W-6:0], 5'b0}
                  + {acc_r[NUM_W-3:0], 2'b0};
  assign acc_step = (dig_r == DIG_W'(1) && odd_r) ? acc_x10 + NUM_W'(hi)
                  : acc_x100 + NUM_W'(hi_x10) + NUM_W'(lo);

  always_comb begin
    phase_nxt  = phase_r;
    rbl_nxt    = rbl_r;
    fc_nxt     = fc_r;
    dig_nxt    = dig_r;
    odd_nxt    = odd_r;
    acc_nxt    = acc_r;
    caller_nxt = caller_r;
    callee_nxt = callee_r;
    date_nxt   = date_r;
    dur_nxt    = dur_r;
    ans_nxt    = ans_r;
    do_finish  = 1'b0;
    res_valid  = 1'b0;

    if (xfer.take) begin
      // the record count moves only on bytes that are taken
      rbl_nxt = rbl_dec;
      unique case (phase_r)
        PH_TAIL: begin
          if (rbl_dec == '0) phase_nxt = PH_SEEK;
        end
        PH_LEN: begin
          rbl_nxt    = (b != '0) ? b - RBL_W'(1) : '0;
          caller_nxt = '0;
          callee_nxt = '0;
          dur_nxt    = '0;
          ans_nxt    = 1'b0;
          fc_nxt     = '0;
          phase_nxt  = PH_SKIP_A;
        end
        PH_SKIP_A, PH_SKIP_B: begin
          fc_nxt = fc_inc;
          if (fc_inc >= FC_W'(SKIP_BYTES)) begin
            fc_nxt    = '0;
            phase_nxt = (phase_r == PH_SKIP_A) ? PH_ANSWER : PH_ALEN;
          end
        end
        PH_ANSWER: begin
          ans_nxt   = b[ANSWER_BIT];
          phase_nxt = PH_SKIP_B;
        end
        PH_ALEN, PH_BLEN: begin
          odd_nxt = len6[0];
          dig_nxt = dig_start;
          acc_nxt = '0;
          if (dig_start != '0) begin
            phase_nxt = (phase_r == PH_ALEN) ? PH_ADIG : PH_BDIG;
          end else if (phase_r == PH_ALEN) begin
            caller_nxt = '0;
            phase_nxt  = PH_TAG100;
          end else begin
            callee_nxt = '0;
            phase_nxt  = PH_TAG168;
          end
        end
        PH_ADIG, PH_BDIG: begin
          acc_nxt = acc_step;
          dig_nxt = dig_dec;
          if (dig_dec == '0) begin
            if (phase_r == PH_ADIG) begin
              caller_nxt = acc_step;
              phase_nxt  = PH_TAG100;
            end else begin
              callee_nxt = acc_step;
              phase_nxt  = PH_TAG168;
            end
          end
        end
        PH_TAG100: begin
          if (b == TAG_DATE) begin
            fc_nxt    = '0;
            phase_nxt = PH_DATE;
          end else if (b == TAG_BNUM) begin
            phase_nxt = PH_BLEN;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_DATE: begin
          for (int k = 0; k < DATE_BYTES; k++) begin
            if (fc_r == FC_W'(k)) date_nxt[k] = b;
          end
          fc_nxt = fc_inc;
          if (fc_inc >= FC_W'(DATE_BYTES)) phase_nxt = PH_DSKIP;
        end
        PH_DSKIP: begin
          fc_nxt    = '0;
          phase_nxt = PH_DUR;
        end
        PH_DUR: begin
          // duration arrives low byte first
          for (int k = 0; k < DUR_BYTES; k++) begin
            if (fc_r == FC_W'(k)) dur_nxt[k*BYTE_W +: BYTE_W] = dur_r[k*BYTE_W +: BYTE_W] | b;
          end
          fc_nxt = fc_inc;
          if (fc_inc >= FC_W'(DUR_BYTES)) phase_nxt = PH_TAG101;
        end
        PH_TAG101: begin
          if (b == TAG_BNUM) begin
            phase_nxt = PH_BLEN;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_TAG168: begin
          do_finish = 1'b1;
        end
        default: begin
          // seeking, and any code with no meaning
          rbl_nxt   = rbl_r;
          phase_nxt = (b == MARKER_BYTE) ? PH_LEN : PH_SEEK;
        end
      endcase

      // closing byte must lie inside the declared length
      if (do_finish) begin
        if (rbl_dec == '0) begin
          phase_nxt = PH_SEEK;
        end else begin
          res_valid = 1'b1;
          rbl_nxt   = rbl_dec - RBL_W'(1);
          phase_nxt = (rbl_dec != RBL_W'(1)) ? PH_TAIL : PH_SEEK;
        end
      end
    end
  end

  always_comb begin
    res.answered      = ans_r;
    res.caller_number = caller_r;
    res.callee_number = callee_r;
    res.year_value    = date_r[0];
    res.month_value   = date_r[1];
    res.day_value     = date_r[2];
    res.hour_value    = date_r[3];
    res.minute_value  = date_r[4];
    res.second_value  = date_r[5];
    res.duration      = dur_r;
    res.tag168_seen   = end_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      rbl_r    <= '0;
      fc_r     <= '0;
      dig_r    <= '0;
      odd_r    <= 1'b0;
      acc_r    <= '0;
      caller_r <= '0;
      callee_r <= '0;
      for (int k = 0; k < DATE_BYTES; k++) date_r[k] <= '0;
      dur_r    <= '0;
      ans_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rbl_r    <= rbl_nxt;
      fc_r     <= fc_nxt;
      dig_r    <= dig_nxt;
      odd_r    <= odd_nxt;
      acc_r    <= acc_nxt;
      caller_r <= caller_nxt;
      callee_r <= callee_nxt;
      for (int k = 0; k < DATE_BYTES; k++) date_r[k] <= date_nxt[k];
      dur_r    <= dur_nxt;
      ans_r    <= ans_nxt;
    end
  end

endmodule

// ===== rtl/core/crsp_out_reg.sv =====
// result register toward the output stream
`timescale 1ns / 1ps

module crsp_out_reg
  import crsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  record_t               res,
  output logic                  advance,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    vld_r, vld_nxt;
  record_t rec_r, rec_nxt;

  // parser may step whenever the held result is gone or leaving now
  assign advance = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    rec_nxt = rec_r;
    if (res_valid) begin
      vld_nxt = 1'b1;
      rec_nxt = res;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    rec_r <= rec_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {(OUT_DATA_W - RECORD_W)'(0), rec_r};

endmodule

// ===== rtl/core/call_record_stream_parser_top.sv =====
// top level of the call record stream parser
`timescale 1ns / 1ps

// Parses a billing-record byte stream at one byte per clock, sustained while
// the output side takes records. Each byte goes into an input register and is
// parsed by the record state machine once the output register lets it step;
// when it closes a record, the record lands in the output register at the end
// of that cycle. A byte is accepted every cycle as long as the output side
// takes records; a stalled output holds one record while the input register
// still takes one more byte. Records whose fields overrun the declared length
// are dropped silently, and date/time fields keep the last parsed tag 100
// group.

module call_record_stream_parser_top
  import crsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] answered, [64:1] caller_number, [128:65] callee_number,
  // [136:129] year_value, [144:137] month_value, [152:145] day_value,
  // [160:153] hour_value, [168:161] minute_value, [176:169] second_value,
  // [200:177] duration, [201] tag168_seen, [207:202] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       advance;
  byte_xfer_t xfer;
  logic       res_valid;
  record_t    res;

  crsp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .xfer      (xfer)
  );

  crsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .xfer      (xfer),
    .res_valid (res_valid),
    .res       (res)
  );

  crsp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the call record stream parser
`timescale 1ns / 1ps

module tb;
  import crsp_pkg::*;

  // tracks the parser state byte by byte and holds the records it should emit
  class call_record_checker;
    phase_t            stage;
    logic [RBL_W-1:0]  left_in_record;
    logic [FC_W-1:0]   field_idx;
    logic [DIG_W-1:0]  digit_bytes_due;
    logic              odd_len;
    logic [NUM_W-1:0]  num_acc;
    logic [BYTE_W-1:0] date_bytes [DATE_BYTES];
    record_t           held;
    record_t           records_due [$];
    int                errors;

    function new();
      stage           = PH_SEEK;
      left_in_record  = '0;
      field_idx       = '0;
      digit_bytes_due = '0;
      odd_len         = 1'b0;
      num_acc         = '0;
      held            = '0;
      errors          = 0;
      foreach (date_bytes[i]) date_bytes[i] = '0;
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    function void open_number(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] n;
      n = (b > LEN_LIMIT) ? (b & LEN_MASK) : b;
      odd_len         = n[0];
      digit_bytes_due = n[5:1] + {4'd0, n[0]};
      num_acc         = '0;
    endfunction

    function void add_digits(logic [BYTE_W-1:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b[7:4];
      lo = b[3:0];
      // odd count: the low nibble of the last byte is padding
      if (digit_bytes_due == 1 && odd_len)
        num_acc = num_acc * 64'd10 + 64'(hi);
      else
        num_acc = num_acc * 64'd100 + 64'(hi) * 64'd10 + 64'(lo);
      if (digit_bytes_due != 0) digit_bytes_due = digit_bytes_due - 1'b1;
    endfunction

    function void close_record(logic saw_end_tag);
      record_t rec;
      if (left_in_record == 0) begin
        // closing byte past the declared length: drop
        stage = PH_SEEK;
        return;
      end
      rec              = held;
      rec.year_value   = date_bytes[0];
      rec.month_value  = date_bytes[1];
      rec.day_value    = date_bytes[2];
      rec.hour_value   = date_bytes[3];
      rec.minute_value = date_bytes[4];
      rec.second_value = date_bytes[5];
      rec.tag168_seen  = saw_end_tag;
      records_due.push_back(rec);
      left_in_record = left_in_record - 1'b1;
      stage = (left_in_record != 0) ? PH_TAIL : PH_SEEK;
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] b);
      if (stage == PH_TAIL) begin
        if (left_in_record != 0) left_in_record = left_in_record - 1'b1;
        if (left_in_record == 0) stage = PH_SEEK;
        return;
      end
      if (stage == PH_SEEK) begin
        stage = (b == MARKER_BYTE) ? PH_LEN : PH_SEEK;
        return;
      end
      if (left_in_record != 0) left_in_record = left_in_record - 1'b1;
      case (stage)
        PH_LEN: begin
          left_in_record       = (b == 0) ? '0 : b - 1'b1;
          held.answered        = 1'b0;
          held.caller_number   = '0;
          held.callee_number   = '0;
          held.duration        = '0;
          field_idx            = '0;
          stage                = PH_SKIP_A;
        end
        PH_SKIP_A, PH_SKIP_B: begin
          field_idx = field_idx + 1'b1;
          if (field_idx >= SKIP_BYTES) begin
            field_idx = '0;
            stage = (stage == PH_SKIP_A) ? PH_ANSWER : PH_ALEN;
          end
        end
        PH_ANSWER: begin
          held.answered = b[ANSWER_BIT];
          stage = PH_SKIP_B;
        end
        PH_ALEN: begin
          open_number(b);
          if (digit_bytes_due != 0) begin
            stage = PH_ADIG;
          end else begin
            held.caller_number = '0;
            stage = PH_TAG100;
          end
        end
        PH_ADIG: begin
          add_digits(b);
          if (digit_bytes_due == 0) begin
            held.caller_number = num_acc;
            stage = PH_TAG100;
          end
        end
        PH_TAG100: begin
          if (b == TAG_DATE) begin
            field_idx = '0;
            stage = PH_DATE;
          end else if (b == TAG_BNUM) begin
            stage = PH_BLEN;
          end else begin
            close_record(b == TAG_END);
          end
        end
        PH_DATE: begin
          if (field_idx < DATE_BYTES) date_bytes[field_idx] = b;
          field_idx = field_idx + 1'b1;
          if (field_idx >= DATE_BYTES) stage = PH_DSKIP;
        end
        PH_DSKIP: begin
          field_idx = '0;
          stage = PH_DUR;
        end
        PH_DUR: begin
          // little-endian duration
          if (field_idx < DUR_BYTES) held.duration[8*field_idx +: 8] = b;
          field_idx = field_idx + 1'b1;
          if (field_idx >= DUR_BYTES) stage = PH_TAG101;
        end
        PH_TAG101: begin
          if (b == TAG_BNUM) stage = PH_BLEN;
          else close_record(b == TAG_END);
        end
        PH_BLEN: begin
          open_number(b);
          if (digit_bytes_due != 0) begin
            stage = PH_BDIG;
          end else begin
            held.callee_number = '0;
            stage = PH_TAG168;
          end
        end
        PH_BDIG: begin
          add_digits(b);
          if (digit_bytes_due == 0) begin
            held.callee_number = num_acc;
            stage = PH_TAG168;
          end
        end
        PH_TAG168: close_record(b == TAG_END);
        default: stage = PH_SEEK;
      endcase
    endfunction

    task report_mismatch(string what, logic [NUM_W-1:0] got, logic [NUM_W-1:0] want);
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_record(record_t got);
      record_t want;
      if (records_due.size() == 0) begin
        report_mismatch("record with none expected", got.caller_number, '0);
        return;
      end
      want = records_due.pop_front();
      if (got.answered !== want.answered)
        report_mismatch("answered", got.answered, want.answered);
      if (got.caller_number !== want.caller_number)
        report_mismatch("caller_number", got.caller_number, want.caller_number);
      if (got.callee_number !== want.callee_number)
        report_mismatch("callee_number", got.callee_number, want.callee_number);
      if (got.year_value !== want.year_value)
        report_mismatch("year_value", got.year_value, want.year_value);
      if (got.month_value !== want.month_value)
        report_mismatch("month_value", got.month_value, want.month_value);
      if (got.day_value !== want.day_value)
        report_mismatch("day_value", got.day_value, want.day_value);
      if (got.hour_value !== want.hour_value)
        report_mismatch("hour_value", got.hour_value, want.hour_value);
      if (got.minute_value !== want.minute_value)
        report_mismatch("minute_value", got.minute_value, want.minute_value);
      if (got.second_value !== want.second_value)
        report_mismatch("second_value", got.second_value, want.second_value);
      if (got.duration !== want.duration)
        report_mismatch("duration", got.duration, want.duration);
      if (got.tag168_seen !== want.tag168_seen)
        report_mismatch("tag168_seen", got.tag168_seen, want.tag168_seen);
    endtask
  endclass

  localparam int PHASE_BYTES = 440;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  call_record_checker chk = new();
  logic [BYTE_W-1:0]  stream_q [$];
  int                 phase_bytes;
  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;

  call_record_stream_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      chk.check_record(record_t'(out_tdata[RECORD_W-1:0]));
  end

  function automatic logic [BYTE_W-1:0] pick_num_len();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return LEN_LIMIT;
      2:       return 8'($urandom_range(33, 255));
      3:       return 8'($urandom_range(17, 31));
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic int digit_bytes_for(logic [BYTE_W-1:0] len);
    logic [BYTE_W-1:0] n;
    n = (len > LEN_LIMIT) ? (len & LEN_MASK) : len;
    return (int'(n) + 1) / 2;
  endfunction

  function automatic logic [BYTE_W-1:0] digit_byte();
    if ($urandom_range(0, 1))
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom_range(0, 255));
  endfunction

  // skipped bytes now and then carry the marker value
  function automatic logic [BYTE_W-1:0] filler_byte();
    if ($urandom_range(0, 7) == 0) return MARKER_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic append_number(logic [BYTE_W-1:0] len);
    stream_q.push_back(len);
    repeat (digit_bytes_for(len)) stream_q.push_back(digit_byte());
  endtask

  task automatic append_record();
    int first;
    int need;
    int total;
    first = stream_q.size();
    stream_q.push_back(MARKER_BYTE);
    stream_q.push_back(8'd0);
    repeat (2) stream_q.push_back(filler_byte());
    stream_q.push_back(8'($urandom_range(0, 255)));
    repeat (2) stream_q.push_back(filler_byte());
    append_number(pick_num_len());
    if ($urandom_range(0, 1)) begin
      stream_q.push_back(TAG_DATE);
      repeat (DATE_BYTES + 1 + DUR_BYTES) stream_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) begin
      stream_q.push_back(TAG_BNUM);
      append_number(pick_num_len());
    end
    stream_q.push_back(($urandom_range(0, 2) != 0) ? TAG_END : 8'($urandom_range(0, 255)));
    need = stream_q.size() - first;
    case ($urandom_range(0, 39))
      0, 1, 2, 3: total = $urandom_range(0, need - 1);   // fields overrun the length
      4:          total = 255;
      default:    total = need + $urandom_range(0, 6);
    endcase
    if (total > 255) total = 255;
    stream_q[first + 1] = 8'(total);
    if (total > need)
      repeat (total - need) stream_q.push_back(filler_byte());
  endtask

  task automatic append_noise();
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(3, 15)) stream_q.push_back(8'($urandom_range(0, 255)));
      1: begin
        // record cut short by the next one
        stream_q.push_back(MARKER_BYTE);
        repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom_range(0, 255)));
      end
      2: stream_q.push_back(TAG_DATE);
      3: stream_q.push_back(TAG_BNUM);
      4: stream_q.push_back(TAG_END);
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_byte(logic [BYTE_W-1:0] b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chk.parse_byte(b);
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic flush_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  task automatic drain_records();
    in_tvalid <= 1'b0;
    for (int n = 0; n < 5000 && chk.pending() != 0; n++) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 84, 0, 25};
    stall_by_phase = '{0, 0, 84, 25};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // filler tags outside a record, an exact-fit record with the marker right
    // after its tail, then a record whose length byte is too short
    stream_q = '{TAG_DATE, TAG_BNUM, TAG_END, 8'hFF, 8'h00,
                 MARKER_BYTE, 8'd10, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'd0, TAG_END, 8'h55,
                 MARKER_BYTE, 8'd1, 8'hFF, 8'hFF, 8'hFB, 8'h00, 8'h00, 8'd1, 8'h9F, 8'h00};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct     = stall_by_phase[p];
      phase_bytes   = 0;
      flush_stream();
      while (phase_bytes < PHASE_BYTES) begin
        append_noise();
        append_record();
        flush_stream();
      end
      // hold the input until every record of this phase is out
      drain_records();
    end
    repeat (20) @(negedge clk);
    if (chk.pending() != 0)
      chk.report_mismatch("records never seen", chk.pending(), '0);
    if (chk.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
